// File: design/djci_pkg.sv
`timescale 1ns / 1ps
package djci_pkg;
  localparam int COORD_W = 17;
  localparam int COEF_W = 18;
  localparam int Q14_W = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int STAGE_W = 4;
  localparam int MAX_COLUMNS = 4096;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic [21:0] PHASE_K = 22'd2670177;
  localparam logic signed [17:0] Y_OFFSET = 18'sd49152;
  localparam int Y_SPAN = 98304;
  localparam logic [15:0] DIV3_RECIP = 16'd43691;
  localparam logic [12:0] ROW_COUNT_RESET = 13'd512;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_ROT, ST_ROUND, ST_NEXT_EVAL,
    ST_COMBINE, ST_ROW_MUL, ST_ROW_DIV, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic rot;
    logic round;
    logic combine;
    logic row_mul;
    logic row_div;
    logic emit;
    logic [1:0] eval_sel;
  } cmd_t;

  typedef struct packed {
    logic rot_done;
    logic steps_zero;
    logic out_free;
  } status_t;

  function automatic logic [31:0] atan_turn(input logic [STAGE_W-1:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        4'd0: r = 32'd536870912;
        4'd1: r = 32'd316933406;
        4'd2: r = 32'd167458907;
        4'd3: r = 32'd85004756;
        4'd4: r = 32'd42667331;
        4'd5: r = 32'd21354465;
        4'd6: r = 32'd10679838;
        4'd7: r = 32'd5340245;
        4'd8: r = 32'd2670163;
        4'd9: r = 32'd1335087;
        4'd10: r = 32'd667544;
        4'd11: r = 32'd333772;
        4'd12: r = 32'd166886;
        4'd13: r = 32'd83443;
        4'd14: r = 32'd41722;
        default: r = 32'd20861;
      endcase
      return r;
    end
  endfunction
endpackage

// File: design/djci_in_if.sv
`timescale 1ns / 1ps
interface djci_in_if;
  logic valid;
  logic ready;
  logic [11:0] col_index;
  logic signed [17:0] coef_a;
  logic signed [17:0] coef_b;
  logic signed [17:0] coef_c;
  logic signed [17:0] coef_d;
  logic signed [16:0] start_x;
  logic signed [16:0] start_y;
  logic [6:0] step_count;
  modport source (output valid, col_index, coef_a, coef_b, coef_c, coef_d, start_x, start_y,
                  step_count, input ready);
  modport sink (input valid, col_index, coef_a, coef_b, coef_c, coef_d, start_x, start_y,
                step_count, output ready);
endinterface

// File: design/djci_out_if.sv
`timescale 1ns / 1ps
interface djci_out_if;
  logic valid;
  logic ready;
  logic [11:0] plot_col;
  logic [11:0] plot_row;
  logic hit;
  logic signed [16:0] cur_x;
  logic signed [16:0] cur_y;
  logic last_step;
  modport source (output valid, plot_col, plot_row, hit, cur_x, cur_y, last_step,
                  input ready);
  modport sink (input valid, plot_col, plot_row, hit, cur_x, cur_y, last_step,
                output ready);
endinterface

// File: design/de_jong_column_iterator_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Contents
// in_ch     in   column, coefficients a-d, start point, step count
// out_ch    out  column, row, hit, point, last step
// cfg       in   row_count write
// Each step takes four sine/cosine evaluations on one shared 16-iteration CORDIC
// rotator, plus the states that check the count, combine, compute the row and emit.
// Emitting each result waits while the output stalls.
// A new item is accepted only after the last result of the previous one is registered.
// Reset is synchronous; row_count returns to 512.
module de_jong_column_iterator_unit #(
  parameter int MAX_STEPS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [12:0] cfg_data,
  djci_in_if.sink in_ch,
  djci_out_if.source out_ch
);
  djci_pkg::cmd_t cmd;
  djci_pkg::status_t status;

  djci_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .status(status), .cmd(cmd)
  );

  djci_datapath #(.MAX_STEPS(MAX_STEPS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule

// File: design/djci_ctrl.sv
`timescale 1ns / 1ps
module djci_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  djci_pkg::status_t status,
  output djci_pkg::cmd_t cmd
);
  djci_pkg::state_t state, state_next;
  logic [1:0] eval_sel, eval_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= djci_pkg::ST_IDLE;
      eval_sel <= 2'd0;
    end else begin
      state <= state_next;
      eval_sel <= eval_sel_next;
    end
  end

  always_comb begin
    state_next = state;
    eval_sel_next = eval_sel;
    unique case (state)
      djci_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = djci_pkg::ST_COMBINE;
          eval_sel_next = 2'd0;
        end
      end
      djci_pkg::ST_MUL1: state_next = djci_pkg::ST_MUL2;
      djci_pkg::ST_MUL2: state_next = djci_pkg::ST_ROT;
      djci_pkg::ST_ROT: if (status.rot_done) state_next = djci_pkg::ST_ROUND;
      djci_pkg::ST_ROUND: begin
        if (eval_sel == 2'd3) begin
          state_next = djci_pkg::ST_NEXT_EVAL;
        end else begin
          eval_sel_next = eval_sel + 2'd1;
          state_next = djci_pkg::ST_MUL1;
        end
      end
      djci_pkg::ST_NEXT_EVAL: state_next = djci_pkg::ST_ROW_MUL;
      djci_pkg::ST_ROW_MUL: state_next = djci_pkg::ST_ROW_DIV;
      djci_pkg::ST_ROW_DIV: state_next = djci_pkg::ST_EMIT;
      djci_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_next = djci_pkg::ST_COMBINE;
          eval_sel_next = 2'd0;
        end
      end
      djci_pkg::ST_COMBINE: begin
        if (status.steps_zero) state_next = djci_pkg::ST_IDLE;
        else state_next = djci_pkg::ST_MUL1;
      end
      default: state_next = djci_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.eval_sel = eval_sel;
    in_ready = 1'b0;
    unique case (state)
      djci_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      djci_pkg::ST_MUL1: cmd.mul1 = 1'b1;
      djci_pkg::ST_MUL2: cmd.mul2 = 1'b1;
      djci_pkg::ST_ROT: cmd.rot = 1'b1;
      djci_pkg::ST_ROUND: cmd.round = 1'b1;
      djci_pkg::ST_NEXT_EVAL: cmd.combine = 1'b1;
      djci_pkg::ST_ROW_MUL: cmd.row_mul = 1'b1;
      djci_pkg::ST_ROW_DIV: cmd.row_div = 1'b1;
      djci_pkg::ST_EMIT: cmd.emit = status.out_free;
      default: ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == djci_pkg::ST_IDLE) else $error("ready outside idle");
  a_rot_ends: assert property (@(posedge clk) disable iff (rst)
    (state == djci_pkg::ST_ROT && status.rot_done) |=> state == djci_pkg::ST_ROUND)
    else $error("cordic end missed");
  a_eval_round: assert property (@(posedge clk) disable iff (rst)
    state == djci_pkg::ST_NEXT_EVAL |-> $past(eval_sel) == 2'd3)
    else $error("step closed early");
endmodule

// File: design/djci_datapath.sv
`timescale 1ns / 1ps
module djci_datapath #(
  parameter int MAX_STEPS = 64
) (
  input  logic clk,
  input  logic rst,
  input  djci_pkg::cmd_t cmd,
  output djci_pkg::status_t status,
  input  logic cfg_we,
  input  logic [12:0] cfg_data,
  djci_in_if.sink  in_ch,
  djci_out_if.source out_ch
);
  localparam int COL_W = $clog2(djci_pkg::MAX_COLUMNS);

  logic [12:0] row_count;
  logic [11:0] col;
  logic signed [17:0] coefs [4];
  logic signed [16:0] walk_x, walk_y;
  logic [6:0] steps_left;
  logic signed [35:0] prod;
  logic [1:0] quad;
  logic signed [33:0] cx, cy;
  logic signed [31:0] cz;
  logic [djci_pkg::STAGE_W-1:0] stage;
  logic signed [15:0] s1, c2, s3, c4;
  logic signed [16:0] nx, ny;
  logic [30:0] row_prod;
  logic [11:0] row_q;
  logic hit_r;
  logic out_valid;

  logic signed [17:0] sel_coef;
  logic signed [16:0] sel_pt;
  logic signed [15:0] rc, rs, qc, qs;
  logic signed [33:0] dx, dy;
  logic [57:0] phase_full;
  logic signed [17:0] ny_ext;
  logic [17:0] y_off;
  logic [15:0] row_hi;
  logic [31:0] row_recip;
  logic [12:0] row_div;
  logic [6:0] step_in;

  assign sel_coef = coefs[cmd.eval_sel];
  assign sel_pt = (cmd.eval_sel == 2'd0 || cmd.eval_sel == 2'd3) ? walk_y : walk_x;
  assign phase_full = {{22{prod[35]}}, prod} * {36'd0, djci_pkg::PHASE_K};
  assign dx = cy >>> stage;
  assign dy = cx >>> stage;
  assign rc = 16'((cx + 34'sd32768) >>> 16);
  assign rs = 16'((cy + 34'sd32768) >>> 16);
  always_comb begin
    case (quad)
      2'd0: begin qc = rc; qs = rs; end
      2'd1: begin qc = -rs; qs = rc; end
      2'd2: begin qc = -rc; qs = -rs; end
      default: begin qc = rs; qs = -rc; end
    endcase
  end
  assign ny_ext = 18'(ny);
  assign y_off = 18'(ny_ext + djci_pkg::Y_OFFSET);
  // The span is 3 * 2^15: drop 15 bits, then divide by 3 with a reciprocal.
  assign row_hi = row_prod[30:15];
  assign row_recip = 32'(row_hi) * 32'(djci_pkg::DIV3_RECIP);
  assign row_div = 13'(row_recip >> 17);
  assign step_in = (in_ch.step_count > 7'(MAX_STEPS)) ? 7'(MAX_STEPS) : in_ch.step_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= djci_pkg::ROW_COUNT_RESET;
      steps_left <= '0;
      out_valid <= 1'b0;
      walk_x <= '0;
      walk_y <= '0;
      for (int k = 0; k < 4; k++) coefs[k] <= '0;
    end else begin
      if (cfg_we) row_count <= cfg_data;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (cmd.load) begin
        col <= 12'(in_ch.col_index[COL_W-1:0]);
        coefs[0] <= in_ch.coef_a;
        coefs[1] <= in_ch.coef_b;
        coefs[2] <= in_ch.coef_c;
        coefs[3] <= in_ch.coef_d;
        walk_x <= in_ch.start_x;
        walk_y <= in_ch.start_y;
        steps_left <= step_in;
      end
      if (cmd.mul1) prod <= sel_coef * sel_pt;
      if (cmd.mul2) begin
        stage <= '0;
        quad <= phase_full[51:50];
        cz <= {2'b00, phase_full[49:20]};
        cx <= djci_pkg::CORDIC_START;
        cy <= '0;
      end
      if (cmd.rot) begin
        if (cz >= 0) begin
          cx <= cx - dx; cy <= cy + dy;
          cz <= cz - $signed(djci_pkg::atan_turn(stage));
        end else begin
          cx <= cx + dx; cy <= cy - dy;
          cz <= cz + $signed(djci_pkg::atan_turn(stage));
        end
        stage <= stage + 1'b1;
      end
      if (cmd.round) begin
        case (cmd.eval_sel)
          2'd0: s1 <= qs;
          2'd1: c2 <= qc;
          2'd2: s3 <= qs;
          default: c4 <= qc;
        endcase
      end
      if (cmd.combine) begin
        nx <= 17'(s1) - 17'(c2);
        ny <= 17'(s3) - 17'(c4);
        walk_x <= 17'(s1) - 17'(c2);
        walk_y <= 17'(s3) - 17'(c4);
        steps_left <= steps_left - 7'd1;
      end
      if (cmd.row_mul) begin
        hit_r <= (ny_ext >= -djci_pkg::Y_OFFSET) && (ny_ext < djci_pkg::Y_OFFSET);
        row_prod <= 31'(y_off) * 31'(row_count);
      end
      if (cmd.row_div) begin
        row_q <= !hit_r ? 12'd0 : (row_div > 13'd4095) ? 12'd4095 : row_div[11:0];
      end
    end
  end

  assign status.rot_done = (stage == 4'(djci_pkg::CORDIC_STAGES - 1));
  assign status.steps_zero = (steps_left == '0);
  assign status.out_free = !out_valid || out_ch.ready;

  logic [11:0] o_col, o_row;
  logic o_hit, o_last;
  logic signed [16:0] o_x, o_y;
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_col <= col;
      o_row <= row_q;
      o_hit <= hit_r;
      o_x <= nx;
      o_y <= ny;
      o_last <= (steps_left == '0);
    end
  end
  assign out_ch.valid = out_valid;
  assign out_ch.plot_col = o_col;
  assign out_ch.plot_row = o_row;
  assign out_ch.hit = o_hit;
  assign out_ch.cur_x = o_x;
  assign out_ch.cur_y = o_y;
  assign out_ch.last_step = o_last;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> out_valid && $stable(o_y))
    else $error("result lost");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (hit_r || row_q == 12'd0)) else $error("row without hit");
  a_load_steps: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> steps_left <= 7'(MAX_STEPS)) else $error("step count not saturated");
endmodule
